>>> hw/rtl/single_wire_sensor_frame_decoder_macros.svh
// Assertion macros for the single-wire sensor frame decoder.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_MACROS_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_MACROS_SVH
`ifndef SYNTH
`define SWSFD_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swsfd assertion failed");
`define SWSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swsfd assertion failed");
`else
`define SWSFD_ASSERT(label, clk, rst_n, ante, cons)
`define SWSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/swsfd_pkg.sv
// Types and constants of the single-wire sensor frame decoder.
// No dependencies; used by single_wire_sensor_frame_decoder.
package swsfd_pkg;

  localparam int TimeW = 32;
  localparam int CountW = 7;
  localparam int ThrW = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;

  // Item kinds.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_EDGE  = 2'd1;
  localparam logic [1:0] FUNC_POLL  = 2'd2;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CFG_BIT_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_EXPECTED      = 2'd2;

  // Register reset values.
  localparam logic [ThrW-1:0]   THRESHOLD_RST = 8'd35;
  localparam logic [TimeW-1:0]  TIMEOUT_RST   = 32'd4000000;
  localparam logic [CountW-1:0] EXPECTED_RST  = 7'd84;

  // The first payload bit arrives on this edge.
  localparam logic [CountW-1:0] FIRST_BIT_EDGE = 7'd5;

  typedef struct packed {
    logic [1:0]       func;
    logic [TimeW-1:0] time_us;
  } in_t;

  typedef struct packed {
    logic [15:0]       humidity_tenths;
    logic [15:0]       temperature_tenths;
    logic [7:0]        checksum_byte;
    logic              timed_out;
    logic [CountW-1:0] edges_seen;
  } out_t;

endpackage

>>> hw/rtl/single_wire_sensor_frame_decoder.sv
// Top level of the single-wire sensor frame decoder: input register, frame state,
// two-entry result queue. Depends on swsfd_pkg and the assertion macro header.
//
//   Channel  Signals                         Direction  Carries
//   in       in_valid_i/in_ready_o/in_data_i  input      start, edge or poll word
//   out      out_valid_o/out_ready_i/out_data_o output   finished frame word
//   cfg      cfg_we_i/cfg_idx_i/cfg_wdata_i   input      register write, no handshake
//
// One word is taken per cycle while the input is not stalled. A taken word is
// processed from the input register once the skid register is empty: the frame
// update and end-of-frame decision are made there, and a result goes to the output or skid register.
// The result register and a skid register behind it let input continue while the
// output is stalled; the input register holds its word while the skid register is
// full, and the input stalls only when that word is also waiting. Reset is
// asynchronous and active low, leaves the block idle and loads the register defaults.
`include "single_wire_sensor_frame_decoder_macros.svh"

module single_wire_sensor_frame_decoder #(
  parameter int PAYLOAD_BYTE_COUNT = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  swsfd_pkg::in_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output swsfd_pkg::out_t                     out_data_o,
  input  logic                                cfg_we_i,
  input  logic [swsfd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [swsfd_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int PayloadBits = 8 * PAYLOAD_BYTE_COUNT;
  localparam int CountW = swsfd_pkg::CountW;
  localparam int TimeW = swsfd_pkg::TimeW;

  // Configuration registers.
  logic [swsfd_pkg::ThrW-1:0] thr_q;
  logic [TimeW-1:0]           timeout_q;
  logic [CountW-1:0]          expected_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= swsfd_pkg::THRESHOLD_RST;
      timeout_q  <= swsfd_pkg::TIMEOUT_RST;
      expected_q <= swsfd_pkg::EXPECTED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swsfd_pkg::CFG_BIT_THRESHOLD: thr_q      <= cfg_wdata_i[swsfd_pkg::ThrW-1:0];
        swsfd_pkg::CFG_TIMEOUT:       timeout_q  <= cfg_wdata_i[TimeW-1:0];
        swsfd_pkg::CFG_EXPECTED:      expected_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic           item_valid_q;
  swsfd_pkg::in_t item_q;
  logic           skid_valid_q;
  logic           advance;

  assign advance    = item_valid_q && !skid_valid_q;
  assign in_ready_o = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  // Frame state.
  logic                   listening_q, listening_d;
  logic [CountW-1:0]      edge_cnt_q, edge_cnt_d;
  logic                   have_last_q, have_last_d;
  logic [TimeW-1:0]       last_time_q, last_time_d;
  logic [TimeW-1:0]       start_time_q, start_time_d;
  logic [PayloadBits-1:0] payload_q, payload_d;

  logic [TimeW-1:0]  interval;
  logic [TimeW-1:0]  since_start;
  logic [CountW-1:0] cnt_inc;
  logic [CountW-1:0] bit_off;
  logic [5:0]        bit_idx;
  logic              bit_set;
  logic              bit_val;
  logic              emit;
  logic              timed;

  assign cnt_inc     = edge_cnt_q + 7'd1;
  assign interval    = have_last_q ? (item_q.time_us - last_time_q) : '0;
  assign since_start = item_q.time_us - start_time_q;
  assign bit_off     = cnt_inc - swsfd_pkg::FIRST_BIT_EDGE;
  assign bit_idx     = bit_off[CountW-1:1];
  assign bit_val     = interval > {{(TimeW - swsfd_pkg::ThrW){1'b0}}, thr_q};
  // Odd edges from the fifth on carry bits; bits past the payload fall away.
  assign bit_set     = (cnt_inc >= swsfd_pkg::FIRST_BIT_EDGE) && cnt_inc[0] &&
                       ({1'b0, bit_idx} < 7'(PayloadBits)) && bit_val;

  always_comb begin
    listening_d  = listening_q;
    edge_cnt_d   = edge_cnt_q;
    have_last_d  = have_last_q;
    last_time_d  = last_time_q;
    start_time_d = start_time_q;
    payload_d    = payload_q;
    emit         = 1'b0;
    timed        = 1'b0;
    if (advance) begin
      case (item_q.func)
        swsfd_pkg::FUNC_START: begin
          listening_d  = 1'b1;
          edge_cnt_d   = '0;
          have_last_d  = 1'b0;
          last_time_d  = '0;
          start_time_d = item_q.time_us;
          payload_d    = '0;
        end
        swsfd_pkg::FUNC_EDGE: begin
          if (listening_q) begin
            edge_cnt_d  = cnt_inc;
            have_last_d = 1'b1;
            last_time_d = item_q.time_us;
            for (int j = 0; j < PayloadBits; j++) begin
              payload_d[j] = payload_q[j] |
                             (bit_set && (bit_idx == 6'(PayloadBits - 1 - j)));
            end
            emit = cnt_inc >= expected_q;
          end
        end
        swsfd_pkg::FUNC_POLL: begin
          if (listening_q && (since_start > timeout_q)) begin
            emit  = 1'b1;
            timed = 1'b1;
          end
        end
        default: ;
      endcase
      if (emit) begin
        listening_d  = 1'b0;
        edge_cnt_d   = '0;
        have_last_d  = 1'b0;
        last_time_d  = '0;
        start_time_d = '0;
        payload_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listening_q  <= 1'b0;
      edge_cnt_q   <= '0;
      have_last_q  <= 1'b0;
      last_time_q  <= '0;
      start_time_q <= '0;
      payload_q    <= '0;
    end else begin
      listening_q  <= listening_d;
      edge_cnt_q   <= edge_cnt_d;
      have_last_q  <= have_last_d;
      last_time_q  <= last_time_d;
      start_time_q <= start_time_d;
      payload_q    <= payload_d;
    end
  end

  // The result is built from the frame as it stands after this word, before
  // the clear; payload_d is only cleared after emit, so take the updated bits.
  // Bytes beyond the payload read as zero.
  logic [PayloadBits-1:0] payload_upd;
  swsfd_pkg::out_t        res;

  always_comb begin
    payload_upd = payload_q;
    for (int j = 0; j < PayloadBits; j++) begin
      payload_upd[j] = payload_q[j] |
                       ((item_q.func == swsfd_pkg::FUNC_EDGE) && bit_set &&
                        (bit_idx == 6'(PayloadBits - 1 - j)));
    end
  end

  logic [7:0] rbyte [5];

  for (genvar k = 0; k < 5; k++) begin : g_rbyte
    if (k < PAYLOAD_BYTE_COUNT) begin : g_have
      assign rbyte[k] = payload_upd[8*(PAYLOAD_BYTE_COUNT-k)-1 -: 8];
    end else begin : g_none
      assign rbyte[k] = 8'h00;
    end
  end

  assign res.humidity_tenths    = {rbyte[0], rbyte[1]};
  assign res.temperature_tenths = {rbyte[2], rbyte[3]};
  assign res.checksum_byte      = rbyte[4];
  assign res.timed_out          = timed;
  assign res.edges_seen         = (item_q.func == swsfd_pkg::FUNC_EDGE) ? cnt_inc : edge_cnt_q;

  // Two-entry result queue: output register with a skid register behind it.
  logic            out_valid_q, out_valid_d;
  logic            skid_valid_d;
  swsfd_pkg::out_t out_q, out_d;
  swsfd_pkg::out_t skid_q, skid_d;
  logic            push;
  logic            pop;

  assign push = emit;
  assign pop  = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q) begin
      if (push) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        out_d = res;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SWSFD_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `SWSFD_ASSERT_NEXT(a_emit_goes_idle, clk_i, rst_ni, push, !listening_q)
  `SWSFD_ASSERT(a_count_needs_frame, clk_i, rst_ni, edge_cnt_q != '0, listening_q)
  `SWSFD_ASSERT(a_idle_no_last_edge, clk_i, rst_ni, !listening_q, !have_last_q)
  `SWSFD_ASSERT(a_idle_payload_clear, clk_i, rst_ni, !listening_q, payload_q == '0)

endmodule
